// ----- rtl/core/consensus_leader_election_unit_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the consensus leader election unit
// Checks compile to nothing when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef CONSENSUS_LEADER_ELECTION_UNIT_DEFINES_SVH
`define CONSENSUS_LEADER_ELECTION_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define CLE_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define CLE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define CLE_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)
`define CLE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

// ----- rtl/core/cle_pkg.sv -----
// ----------------------------------------------------------------------------
// cle_pkg
// Types and constants shared by the leader election unit.
// ----------------------------------------------------------------------------
`default_nettype none

package cle_pkg;

    localparam int unsigned TERM_W    = 32;
    localparam int unsigned LOG_W     = 32;
    localparam int unsigned ID_W      = 4;
    localparam int unsigned VOTE_ID_W = 5;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DAT_W = 4;

    localparam logic [TERM_W-1:0]    TERM_MAX  = '1;
    localparam logic [VOTE_ID_W-1:0] VOTE_NONE = 5'd16;

    localparam logic [CFG_IDX_W-1:0] CFG_NODE_ID    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PEER_COUNT = 2'd1;

    localparam logic [CFG_DAT_W-1:0] PEER_COUNT_RST = 4'd4;

    typedef enum logic [1:0] {
        OP_TIMEOUT      = 2'd0,
        OP_VOTE_REPLY   = 2'd1,
        OP_VOTE_REQUEST = 2'd2,
        OP_LOG_UPDATE   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ROLE_FOLLOWER  = 2'd0,
        ROLE_CANDIDATE = 2'd1,
        ROLE_LEADER    = 2'd2
    } role_t;

    typedef struct packed {
        op_t              operation;
        logic [TERM_W-1:0] msg_term;
        logic [TERM_W-1:0] asked_term;
        logic              granted;
        logic [ID_W-1:0]   candidate_id;
        logic [TERM_W-1:0] log_term;
        logic [LOG_W-1:0]  log_index;
    } cle_in_t;

    typedef struct packed {
        role_t                role;
        logic [TERM_W-1:0]    term_now;
        logic [VOTE_ID_W-1:0] vote_holder;
        logic                 send_requests;
        logic [LOG_W-1:0]     own_log_index;
        logic [TERM_W-1:0]    own_log_term;
        logic                 reply_ready;
        logic                 vote_given;
        logic                 persist;
        logic                 restart_timer;
        logic                 won_election;
    } cle_out_t;

endpackage

`default_nettype wire

// ----- rtl/core/consensus_leader_election_unit.sv -----
// ----------------------------------------------------------------------------
// consensus_leader_election_unit
// Election side of a replicated-log consensus node: one event in, one result out.
// ----------------------------------------------------------------------------
// Path: an accepted event sits in the input register, then its result is loaded
// into the result register, where m_valid rises until the downstream side takes it.
// Throughput: one event per cycle while the result slot is free or drains; the
// loop through the election update logic and its state registers sets this rate.
// Reset (aresetn low, synchronous): follower, term 0, no vote, empty tally,
// own log 0/0, node_id 0, peer_count 4, both stages empty.
`default_nettype none

module consensus_leader_election_unit #(
    parameter int unsigned MAX_NODES = 16
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_we,
    input  wire logic [cle_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [cle_pkg::CFG_DAT_W-1:0]  cfg_wdata,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire cle_pkg::cle_in_t               s_data,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output cle_pkg::cle_out_t                   m_data
);
    import cle_pkg::*;

    logic     take;
    logic     item_valid;
    cle_in_t  item;
    cle_out_t result;

    cle_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    cle_engine #(
        .MAX_NODES (MAX_NODES)
    ) u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .step      (take),
        .item      (item),
        .result    (result)
    );

    cle_out_stage u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (item_valid),
        .result     (result),
        .take       (take),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule

`default_nettype wire

// ----- rtl/core/cle_in_stage.sv -----
// ----------------------------------------------------------------------------
// cle_in_stage
// Input register: holds one accepted event until the engine consumes it.
// ----------------------------------------------------------------------------
`default_nettype none

module cle_in_stage (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire cle_pkg::cle_in_t s_data,
    input  wire logic             take,
    output logic                  item_valid,
    output cle_pkg::cle_in_t      item
);
    import cle_pkg::*;

    logic    vld_reg;
    logic    vld_next;
    logic    load;
    cle_in_t data_reg;

    // accept when empty or when the held item leaves this cycle
    assign s_ready  = !vld_reg || take;
    assign load     = s_valid && s_ready;
    assign vld_next = load || (vld_reg && !take);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= s_data;
        end
    end

    assign item_valid = vld_reg;
    assign item       = data_reg;

endmodule

`default_nettype wire

// ----- rtl/core/cle_engine.sv -----
// ----------------------------------------------------------------------------
// cle_engine
// Election state, configuration registers and the per-event update logic.
// ----------------------------------------------------------------------------
`default_nettype none

`include "consensus_leader_election_unit_defines.svh"

module cle_engine #(
    parameter int unsigned MAX_NODES = 16
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_we,
    input  wire logic [cle_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [cle_pkg::CFG_DAT_W-1:0]  cfg_wdata,
    input  wire logic                           step,
    input  wire cle_pkg::cle_in_t               item,
    output cle_pkg::cle_out_t                   result
);
    import cle_pkg::*;

    localparam int unsigned VOTE_CAP = (MAX_NODES < 31) ? MAX_NODES : 31;
    localparam int unsigned VOTE_W   = $clog2(VOTE_CAP + 1);

    logic [ID_W-1:0]      node_id_reg;
    logic [CFG_DAT_W-1:0] peer_count_reg;

    role_t                role_reg,    role_next;
    logic [TERM_W-1:0]    term_reg,    term_next;
    logic [VOTE_ID_W-1:0] voted_reg,   voted_next;
    logic [VOTE_W-1:0]    votes_reg,   votes_next;
    logic [LOG_W-1:0]     llidx_reg,   llidx_next;
    logic [TERM_W-1:0]    llterm_reg,  llterm_next;

    logic [VOTE_ID_W-1:0] needed;
    logic                 can_vote;
    logic                 up_to_date;
    logic                 send, reply, given, persist, restart, won;

    // majority threshold: (peers + 1) / 2 + 1
    assign needed = ((VOTE_ID_W'(peer_count_reg) + 5'd1) >> 1) + 5'd1;

    always_comb begin
        role_next   = role_reg;
        term_next   = term_reg;
        voted_next  = voted_reg;
        votes_next  = votes_reg;
        llidx_next  = llidx_reg;
        llterm_next = llterm_reg;
        send        = 1'b0;
        reply       = 1'b0;
        given       = 1'b0;
        persist     = 1'b0;
        restart     = 1'b0;
        won         = 1'b0;
        can_vote    = 1'b0;
        up_to_date  = 1'b0;

        unique case (item.operation)
            OP_TIMEOUT: begin
                if (role_reg != ROLE_LEADER) begin
                    role_next = ROLE_CANDIDATE;
                    if (term_reg != TERM_MAX) begin
                        term_next = term_reg + 32'd1;
                    end
                    voted_next = VOTE_ID_W'(node_id_reg);
                    votes_next = VOTE_W'(1);
                    send       = 1'b1;
                    persist    = 1'b1;
                    restart    = 1'b1;
                end
            end
            OP_VOTE_REPLY: begin
                if (role_reg == ROLE_CANDIDATE && term_reg == item.asked_term) begin
                    if (item.msg_term > term_reg) begin
                        role_next  = ROLE_FOLLOWER;
                        term_next  = item.msg_term;
                        voted_next = VOTE_NONE;
                        persist    = 1'b1;
                    end else if (item.granted) begin
                        // saturate the tally
                        if (votes_reg < VOTE_W'(VOTE_CAP)) begin
                            votes_next = votes_reg + VOTE_W'(1);
                        end
                        // win only on exact match with the threshold
                        if (VOTE_ID_W'(votes_next) == needed) begin
                            role_next = ROLE_LEADER;
                            won       = 1'b1;
                        end
                    end
                end
            end
            OP_VOTE_REQUEST: begin
                reply = 1'b1;
                if (item.msg_term >= term_reg) begin
                    if (item.msg_term > term_reg) begin
                        role_next  = ROLE_FOLLOWER;
                        term_next  = item.msg_term;
                        voted_next = VOTE_NONE;
                        persist    = 1'b1;
                    end
                    can_vote   = (voted_next == VOTE_NONE) ||
                                 (voted_next == VOTE_ID_W'(item.candidate_id));
                    up_to_date = (item.log_term > llterm_reg) ||
                                 (item.log_term == llterm_reg &&
                                  item.log_index >= llidx_reg);
                    if (can_vote && up_to_date) begin
                        voted_next = VOTE_ID_W'(item.candidate_id);
                        given      = 1'b1;
                        persist    = 1'b1;
                        restart    = 1'b1;
                    end
                end
            end
            OP_LOG_UPDATE: begin
                llterm_next = item.log_term;
                llidx_next  = item.log_index;
            end
        endcase
    end

    always_comb begin
        result.role          = role_next;
        result.term_now      = term_next;
        result.vote_holder   = voted_next;
        result.send_requests = send;
        result.own_log_index = llidx_next;
        result.own_log_term  = llterm_next;
        result.reply_ready   = reply;
        result.vote_given    = given;
        result.persist       = persist;
        result.restart_timer = restart;
        result.won_election  = won;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            node_id_reg    <= '0;
            peer_count_reg <= PEER_COUNT_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_NODE_ID:    node_id_reg    <= cfg_wdata;
                CFG_PEER_COUNT: peer_count_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            role_reg   <= ROLE_FOLLOWER;
            term_reg   <= '0;
            voted_reg  <= VOTE_NONE;
            votes_reg  <= '0;
            llidx_reg  <= '0;
            llterm_reg <= '0;
        end else if (step) begin
            role_reg   <= role_next;
            term_reg   <= term_next;
            voted_reg  <= voted_next;
            votes_reg  <= votes_next;
            llidx_reg  <= llidx_next;
            llterm_reg <= llterm_next;
        end
    end

    `CLE_ASSERT_IMPLY(a_active_has_vote, aclk, aresetn, role_reg != ROLE_FOLLOWER, voted_reg != VOTE_NONE, "candidate or leader without a recorded vote")
    `CLE_ASSERT_IMPLY(a_candidate_counts, aclk, aresetn, role_reg == ROLE_CANDIDATE, votes_reg != '0, "candidate with empty vote tally")
    `CLE_ASSERT_NEXT(a_term_monotonic, aclk, aresetn, step, term_reg >= $past(term_reg), "term went backwards")
    `CLE_ASSERT_NEXT(a_timeout_campaigns, aclk, aresetn, step && item.operation == OP_TIMEOUT && role_reg != ROLE_LEADER, role_reg == ROLE_CANDIDATE && voted_reg == VOTE_ID_W'($past(node_id_reg)), "timeout did not start a campaign")

endmodule

`default_nettype wire

// ----- rtl/core/cle_out_stage.sv -----
// ----------------------------------------------------------------------------
// cle_out_stage
// Result register: holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module cle_out_stage (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              item_valid,
    input  wire cle_pkg::cle_out_t result,
    output logic                   take,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output cle_pkg::cle_out_t      m_data
);
    import cle_pkg::*;

    logic     vld_reg;
    logic     vld_next;
    cle_out_t data_reg;

    // advance when the slot is free or drains this cycle
    assign take     = item_valid && (!vld_reg || m_ready);
    assign vld_next = take || (vld_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            data_reg <= result;
        end
    end

    assign m_valid = vld_reg;
    assign m_data  = data_reg;

endmodule

`default_nettype wire

// ----- tb/sv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: leader election unit testbench
// Drives timeout, vote reply, vote request and log update events through the
// valid/ready input channel and checks every result against a cycle-free
// election model kept in the bench. Several node id / peer count settings
// are written between drained phases; both sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;
    import cle_pkg::*;

    localparam int unsigned NODE_LIMIT = 16;
    localparam logic [4:0]  VOTE_CAP   = (NODE_LIMIT < 31) ? 5'(NODE_LIMIT) : 5'd31;
    localparam int          STIM_COPY  = 0;
    localparam int          CHECK_COPY = 1;

    // register slots past the last real register; writes there are ignored
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

    typedef struct packed {
        role_t                role;
        logic [TERM_W-1:0]    term;
        logic [VOTE_ID_W-1:0] voted;
        logic [4:0]           votes;
        logic [LOG_W-1:0]     lli;
        logic [TERM_W-1:0]    llt;
        logic [ID_W-1:0]      node_id;
        logic [CFG_DAT_W-1:0] peer_count;
    } node_state_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DAT_W-1:0] cfg_wdata = '0;
    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    cle_in_t              s_data    = '0;
    logic                 m_valid;
    logic                 m_ready   = 1'b0;
    cle_out_t             m_data;

    // one copy of the node follows stimulus generation, the other the transfers
    node_state_t node_view [2];
    cle_in_t     pending_events[$];
    cle_out_t    predicted_results[$];

    int errors       = 0;
    int items_queued = 0;
    int items_sent   = 0;
    int results_seen = 0;
    int hold_left    = 0;
    bit hold_done    = 1'b0;

    consensus_leader_election_unit #(
        .MAX_NODES(NODE_LIMIT)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

    always #1 aclk = ~aclk;

    // Apply one event to a copy of the node and return the result it gives.
    function automatic cle_out_t elect_step(input int view, input cle_in_t ev);
        node_state_t s;
        cle_out_t    r;
        logic [4:0]  needed;
        logic        up_to_date;
        s = node_view[view];
        r = '0;
        case (ev.operation)
            OP_TIMEOUT: begin
                if (s.role != ROLE_LEADER) begin
                    s.role = ROLE_CANDIDATE;
                    if (s.term != TERM_MAX) s.term = s.term + 1;
                    s.voted = {1'b0, s.node_id};
                    s.votes = 5'd1;
                    r.send_requests = 1'b1;
                    r.persist = 1'b1;
                    r.restart_timer = 1'b1;
                end
            end
            OP_VOTE_REPLY: begin
                if (s.role == ROLE_CANDIDATE && s.term == ev.asked_term) begin
                    if (ev.msg_term > s.term) begin
                        s.role = ROLE_FOLLOWER;
                        s.term = ev.msg_term;
                        s.voted = VOTE_NONE;
                        r.persist = 1'b1;
                    end else if (ev.granted) begin
                        needed = ({1'b0, s.peer_count} + 5'd1) / 5'd2 + 5'd1;
                        if (s.votes < VOTE_CAP) s.votes = s.votes + 5'd1;
                        // exact match only: a count already past the majority never wins
                        if (s.votes == needed) begin
                            s.role = ROLE_LEADER;
                            r.won_election = 1'b1;
                        end
                    end
                end
            end
            OP_VOTE_REQUEST: begin
                r.reply_ready = 1'b1;
                if (ev.msg_term >= s.term) begin
                    if (ev.msg_term > s.term) begin
                        s.role = ROLE_FOLLOWER;
                        s.term = ev.msg_term;
                        s.voted = VOTE_NONE;
                        r.persist = 1'b1;
                    end
                    up_to_date = (ev.log_term > s.llt) ||
                                 (ev.log_term == s.llt && ev.log_index >= s.lli);
                    if ((s.voted == VOTE_NONE || s.voted == {1'b0, ev.candidate_id}) &&
                        up_to_date) begin
                        s.voted = {1'b0, ev.candidate_id};
                        r.vote_given = 1'b1;
                        r.persist = 1'b1;
                        r.restart_timer = 1'b1;
                    end
                end
            end
            OP_LOG_UPDATE: begin
                s.llt = ev.log_term;
                s.lli = ev.log_index;
            end
        endcase
        r.role          = s.role;
        r.term_now      = s.term;
        r.vote_holder   = s.voted;
        r.own_log_index = s.lli;
        r.own_log_term  = s.llt;
        node_view[view] = s;
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] got,
                                        input logic [31:0] want);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
            errors++;
        end
    endfunction

    function automatic logic [31:0] nudge(input logic [31:0] base);
        case ($urandom_range(7))
            0:       return base - 1;
            1:       return base + 1;
            2:       return base + $urandom_range(2, 5);
            default: return base;
        endcase
    endfunction

    task automatic queue_event(input cle_in_t ev);
        void'(elect_step(STIM_COPY, ev));
        pending_events = {pending_events, ev};
        items_queued++;
    endtask

    task automatic send(input op_t op, input logic [31:0] mterm, input logic [31:0] aterm,
                        input logic gr, input logic [3:0] cand,
                        input logic [31:0] lterm, input logic [31:0] lidx);
        cle_in_t ev;
        ev.operation    = op;
        ev.msg_term     = mterm;
        ev.asked_term   = aterm;
        ev.granted      = gr;
        ev.candidate_id = cand;
        ev.log_term     = lterm;
        ev.log_index    = lidx;
        queue_event(ev);
    endtask

    // granted reply for the election now running
    task automatic grant_vote();
        send(OP_VOTE_REPLY, node_view[STIM_COPY].term, node_view[STIM_COPY].term,
             1'b1, 4'd0, 32'd0, 32'd0);
    endtask

    // Mostly well-formed traffic around the node's own term and log,
    // with a share of fully random events as noise.
    task automatic add_random(input int count, input int timeout_w);
        cle_in_t     ev;
        node_state_t s;
        int          roll;
        for (int k = 0; k < count; k++) begin
            s = node_view[STIM_COPY];
            ev.operation    = op_t'($urandom_range(3));
            ev.msg_term     = $urandom;
            ev.asked_term   = $urandom;
            ev.granted      = $urandom_range(1);
            ev.candidate_id = $urandom_range(15);
            ev.log_term     = $urandom;
            ev.log_index    = $urandom;
            roll = $urandom_range(99);
            if (roll < 8) begin
                // keep as noise
            end else if (roll < 8 + timeout_w) begin
                ev.operation = OP_TIMEOUT;
            end else if (roll < 52) begin
                ev.operation = OP_VOTE_REPLY;
                if (s.role == ROLE_CANDIDATE && $urandom_range(9) != 0) begin
                    ev.asked_term = s.term;
                    case ($urandom_range(9))
                        0:       ev.msg_term = s.term + 1;
                        1:       ev.msg_term = s.term - $urandom_range(1, 3);
                        default: ev.msg_term = s.term;
                    endcase
                    ev.granted = ($urandom_range(4) != 0);
                end
            end else if (roll < 86) begin
                ev.operation = OP_VOTE_REQUEST;
                if ($urandom_range(39) != 0) ev.msg_term = nudge(s.term);
                if (s.voted != VOTE_NONE && $urandom_range(2) == 0)
                    ev.candidate_id = s.voted[ID_W-1:0];
                if ($urandom_range(15) != 0) begin
                    ev.log_term  = nudge(s.llt);
                    ev.log_index = nudge(s.lli);
                end
            end else begin
                ev.operation = OP_LOG_UPDATE;
                if ($urandom_range(9) != 0) begin
                    ev.log_term  = s.llt + $urandom_range(1);
                    ev.log_index = nudge(s.lli);
                end
            end
            queue_event(ev);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        for (int v = 0; v < 2; v++) begin
            if (idx == CFG_NODE_ID) node_view[v].node_id = val;
            else if (idx == CFG_PEER_COUNT) node_view[v].peer_count = val;
        end
    endtask

    task automatic wait_drained();
        while (items_sent != items_queued || predicted_results.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // driver: one transfer per handshake, random gaps outside the quiet window
    always @(posedge aclk) begin
        logic     holding;
        cle_out_t predicted;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            holding = s_valid;
            if (s_valid && s_ready) begin
                predicted = elect_step(CHECK_COPY, s_data);
                predicted_results = {predicted_results, predicted};
                items_sent++;
                holding = 1'b0;
            end
            if (!holding) begin
                if (pending_events.size() != 0 &&
                    ((items_sent >= 360 && items_sent < 460) || $urandom_range(99) >= 32)) begin
                    s_data  <= pending_events.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: compare each result transfer, drive ready with stalls
    always @(posedge aclk) begin
        cle_out_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (predicted_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none, got %h", $time, m_data);
                    errors++;
                end else begin
                    want = predicted_results.pop_front();
                    check_field("role", 32'(m_data.role), 32'(want.role));
                    check_field("term_now", m_data.term_now, want.term_now);
                    check_field("vote_holder", 32'(m_data.vote_holder), 32'(want.vote_holder));
                    check_field("send_requests", 32'(m_data.send_requests),
                                32'(want.send_requests));
                    check_field("own_log_index", m_data.own_log_index, want.own_log_index);
                    check_field("own_log_term", m_data.own_log_term, want.own_log_term);
                    check_field("reply_ready", 32'(m_data.reply_ready), 32'(want.reply_ready));
                    check_field("vote_given", 32'(m_data.vote_given), 32'(want.vote_given));
                    check_field("persist", 32'(m_data.persist), 32'(want.persist));
                    check_field("restart_timer", 32'(m_data.restart_timer),
                                32'(want.restart_timer));
                    check_field("won_election", 32'(m_data.won_election),
                                32'(want.won_election));
                end
            end
            // hold off once for a long stretch so the pipeline backs up
            if (hold_left != 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (!hold_done && results_seen >= 230 && pending_events.size() > 20) begin
                hold_done = 1'b1;
                hold_left = 60;
                m_ready <= 1'b0;
            end else begin
                m_ready <= (results_seen >= 360 && results_seen < 460) ||
                           ($urandom_range(99) >= 32);
            end
        end
    end

    initial begin
        for (int v = 0; v < 2; v++) begin
            node_view[v].role       = ROLE_FOLLOWER;
            node_view[v].term       = '0;
            node_view[v].voted      = VOTE_NONE;
            node_view[v].votes      = '0;
            node_view[v].lli        = '0;
            node_view[v].llt        = '0;
            node_view[v].node_id    = '0;
            node_view[v].peer_count = PEER_COUNT_RST;
        end
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // reset settings: node 0, four peers
        send(OP_VOTE_REPLY,   32'd0, 32'd0, 1'b1, 4'd0, 32'd0, 32'd0);   // follower drops reply
        send(OP_VOTE_REQUEST, 32'd0, 32'd0, 1'b0, 4'd3, 32'd0, 32'd0);
        send(OP_VOTE_REQUEST, 32'd0, 32'd0, 1'b0, 4'd5, 32'd0, 32'd0);   // already voted
        send(OP_VOTE_REQUEST, 32'd0, 32'd0, 1'b0, 4'd3, 32'd0, 32'd0);   // same candidate
        send(OP_LOG_UPDATE,   32'd0, 32'd0, 1'b0, 4'd0, 32'd2, 32'd10);
        send(OP_VOTE_REQUEST, 32'd1, 32'd0, 1'b0, 4'd7, 32'd1, 32'd99);  // newer term, old log
        send(OP_VOTE_REQUEST, 32'd1, 32'd0, 1'b0, 4'd7, 32'd2, 32'd9);
        send(OP_VOTE_REQUEST, 32'd1, 32'd0, 1'b0, 4'd7, 32'd2, 32'd10);
        send(OP_VOTE_REQUEST, 32'd0, 32'd0, 1'b0, 4'd4, 32'd5, 32'd50);  // stale term
        send(OP_TIMEOUT,      '1, '1, 1'b1, 4'hF, '1, '1);
        send(OP_VOTE_REPLY,   32'd2, 32'd1, 1'b1, 4'd0, 32'd0, 32'd0);   // foreign term
        send(OP_VOTE_REPLY,   32'd2, 32'd2, 1'b0, 4'd0, 32'd0, 32'd0);
        send(OP_VOTE_REPLY,   32'd1, 32'd2, 1'b1, 4'd0, 32'd0, 32'd0);
        send(OP_VOTE_REPLY,   32'd2, 32'd2, 1'b1, 4'd0, 32'd0, 32'd0);   // majority
        send(OP_TIMEOUT,      32'd0, 32'd0, 1'b0, 4'd0, 32'd0, 32'd0);   // leader ignores
        send(OP_VOTE_REPLY,   32'd2, 32'd2, 1'b1, 4'd0, 32'd0, 32'd0);
        send(OP_VOTE_REQUEST, 32'd2, 32'd0, 1'b0, 4'd9, 32'd2, 32'd10);  // voted for self
        send(OP_VOTE_REQUEST, 32'd3, 32'd0, 1'b0, 4'd0, 32'd2, 32'd10);  // own id asks
        send(OP_TIMEOUT,      32'd0, 32'd0, 1'b0, 4'd0, 32'd0, 32'd0);
        send(OP_VOTE_REPLY,   32'd5, 32'd4, 1'b1, 4'd0, 32'd0, 32'd0);   // newer term in reply
        send(OP_LOG_UPDATE,   32'd0, 32'd0, 1'b0, 4'd0, '1, '1);
        send(OP_VOTE_REQUEST, 32'd5, 32'd0, 1'b0, 4'd11, '1, '1);
        add_random(90, 15);
        wait_drained();

        write_reg(CFG_NODE_ID, 4'd15);
        write_reg(CFG_PEER_COUNT, 4'd15);
        add_random(90, 15);
        // leave an election open with a few votes, short of the majority
        send(OP_TIMEOUT, 32'd0, 32'd0, 1'b0, 4'd0, 32'd0, 32'd0);
        repeat (3) grant_vote();
        wait_drained();

        // shrink the cluster below the running count: no win this election
        write_reg(CFG_PEER_COUNT, 4'd2);
        write_reg(CFG_NODE_ID, 4'd8);
        repeat (2) grant_vote();
        add_random(80, 15);
        wait_drained();

        // lone node: few timeouts so the tally runs into its cap
        write_reg(CFG_NODE_ID, 4'd7);
        write_reg(CFG_PEER_COUNT, 4'd0);
        add_random(90, 3);
        wait_drained();

        write_reg(CFG_NODE_ID, 4'd3);
        write_reg(CFG_PEER_COUNT, 4'd1);
        write_reg(CFG_SPARE_2, 4'hF);
        write_reg(CFG_SPARE_3, 4'h5);
        add_random(90, 12);
        wait_drained();

        write_reg(CFG_NODE_ID, 4'd12);
        write_reg(CFG_PEER_COUNT, 4'd9);
        add_random(90, 15);
        // push the term to its ceiling
        send(OP_VOTE_REQUEST, TERM_MAX - 1, 32'd0, 1'b0, 4'd6,
             node_view[STIM_COPY].llt, node_view[STIM_COPY].lli);
        send(OP_TIMEOUT, 32'd0, 32'd0, 1'b0, 4'd0, 32'd0, 32'd0);
        send(OP_TIMEOUT, 32'd0, 32'd0, 1'b0, 4'd0, 32'd0, 32'd0);
        grant_vote();
        add_random(40, 15);
        wait_drained();

        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #400000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/cle_pkg.sv
rtl/core/cle_in_stage.sv
rtl/core/cle_engine.sv
rtl/core/cle_out_stage.sv
rtl/core/consensus_leader_election_unit.sv
tb/sv/tb_top.sv
